// File: rtl/wdp_pkg.sv
// Package for the multi-slot watchdog pool.
// Holds the command and result types and the operation, state and action codes.
// No dependencies.
`default_nettype none

package wdp_pkg;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_START  = 3'd1,
		OP_CANCEL = 3'd2,
		OP_KICK   = 3'd3,
		OP_QUERY  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_UNUSED    = 2'd0,
		ST_RUNNING   = 2'd1,
		ST_TRIGGERED = 2'd2,
		ST_CANCELLED = 2'd3
	} slot_st_t;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_NOTIFY = 2'd1,
		ACT_EXIT   = 2'd2,
		ACT_HALT   = 2'd3
	} act_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [2:0]  slot_sel;
		logic [31:0] timeout_len;
		logic [1:0]  action_code;
	} cmd_t;

	typedef struct packed {
		logic        ok;
		logic [2:0]  slot_out;
		logic [1:0]  slot_status;
		logic [31:0] time_left;
		logic [7:0]  fired_mask;
		logic [7:0]  notify_mask;
		logic        exit_request;
		logic        halt_request;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/multi_slot_watchdog_pool_top.sv
// Top level of the multi-slot watchdog pool.
// Command register, slot logic and result register with stream handshakes.
// Depends on wdp_pkg and wdp_slots.
//
// Channel   Direction  Contents
// s_*       in         one command: op in tuser, slot, timeout and action in tdata
// m_*       out        one result per command: status, time left, expiry flags
//
// One command is taken per cycle unless m_* stalls; its result passes both registers.
// All running slot counters are decremented in parallel by a tick, in the slot logic
// between the command register and the result register.
// Reset sets every slot unused and empties both registers.
// A stalled result holds the command register, and the input stalls while both are
// full and the result is not taken.
`default_nettype none

module multi_slot_watchdog_pool_top #(
	parameter int SLOTS     = 8,
	parameter int TIME_BITS = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,  // slot_sel[2:0], timeout_len[34:3], action_code[36:35], zero
	input  wire  [2:0]  s_tuser,  // op[2:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [55:0] m_tdata   // ok, slot_out, slot_status, time_left, fired_mask,
	                              // notify_mask, exit_request, halt_request
);

	logic           valid_s1;
	wdp_pkg::cmd_t  cmd_s1;
	logic           out_valid_q;
	wdp_pkg::res_t  res_q;
	wdp_pkg::res_t  res;
	logic           adv;

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1.op          <= s_tuser;
			cmd_s1.slot_sel    <= s_tdata[2:0];
			cmd_s1.timeout_len <= s_tdata[34:3];
			cmd_s1.action_code <= s_tdata[36:35];
		end
		if (adv) begin
			res_q <= res;
		end
	end

	wdp_slots #(
		.SLOTS     (SLOTS),
		.TIME_BITS (TIME_BITS)
	) u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_en (adv),
		.cmd    (cmd_s1),
		.res    (res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {res_q.halt_request, res_q.exit_request, res_q.notify_mask,
		res_q.fired_mask, res_q.time_left, res_q.slot_status, res_q.slot_out, res_q.ok};

	a_notify_in_fired: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((res_q.notify_mask & ~res_q.fired_mask) == 8'd0))
		else $error("Notify flag set for a slot that did not expire.");

	a_out_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv))
		else $error("Result appeared without a command leaving the command register.");

	a_stage_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(cmd_s1)))
		else $error("Stalled command was lost or changed.");

	a_left_running: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_q.slot_status != wdp_pkg::ST_RUNNING) |-> (res_q.time_left == 32'd0))
		else $error("Time left reported for a slot that is not running.");

endmodule

`default_nettype wire

// File: rtl/wdp_slots.sv
// Slot storage and command logic of the watchdog pool.
// Applies one command to all slots and builds its result combinationally.
// Depends on wdp_pkg.
`default_nettype none

module wdp_slots #(
	parameter int SLOTS     = 8,
	parameter int TIME_BITS = 32
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            cmd_en,
	input  wdp_pkg::cmd_t  cmd,
	output wdp_pkg::res_t  res
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int IDX_W  = (SLOT_W > 3) ? SLOT_W : 3;
	localparam int MASK_W = (SLOTS > 8) ? SLOTS : 8;

	logic [1:0]           state_q   [SLOTS];
	logic [1:0]           action_q  [SLOTS];
	logic [TIME_BITS-1:0] timeout_q [SLOTS];
	logic [TIME_BITS-1:0] cnt_q     [SLOTS];

	logic [1:0]           state_nxt   [SLOTS];
	logic [1:0]           action_nxt  [SLOTS];
	logic [TIME_BITS-1:0] timeout_nxt [SLOTS];
	logic [TIME_BITS-1:0] cnt_nxt     [SLOTS];

	logic [TIME_BITS-1:0] tlen_sat;
	logic [TIME_BITS-1:0] dec;
	logic [IDX_W-1:0]     sel_w;
	logic [SLOT_W-1:0]    sel_idx;
	logic                 sel_ok;
	logic [SLOT_W-1:0]    free_idx;
	logic                 free_found;
	logic [SLOT_W-1:0]    rep_idx;
	logic                 rep_ok;
	logic                 ok;
	logic [2:0]           slot_out;
	logic [MASK_W-1:0]    fired;
	logic [MASK_W-1:0]    notify;
	logic                 ex_req;
	logic                 halt_req;
	logic [1:0]           rep_state;
	logic [TIME_BITS-1:0] rep_cnt;
	logic [31:0]          rep_left;

	generate
		if (TIME_BITS < 32) begin : g_tlen_narrow
			assign tlen_sat = (|cmd.timeout_len[31:TIME_BITS]) ? '1
				: cmd.timeout_len[TIME_BITS-1:0];
		end else begin : g_tlen_wide
			assign tlen_sat = TIME_BITS'(cmd.timeout_len);
		end
		if (TIME_BITS > 32) begin : g_left_wide
			assign rep_left = (|rep_cnt[TIME_BITS-1:32]) ? '1 : rep_cnt[31:0];
		end else begin : g_left_narrow
			assign rep_left = 32'(rep_cnt);
		end
	endgenerate

	assign sel_w   = IDX_W'(cmd.slot_sel);
	assign sel_idx = sel_w[SLOT_W-1:0];
	assign sel_ok  = {29'd0, cmd.slot_sel} < 32'(SLOTS);

	always_comb begin
		free_idx   = '0;
		free_found = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (state_q[i] != wdp_pkg::ST_RUNNING) begin
				free_idx   = SLOT_W'(i);
				free_found = 1'b1;
			end
		end
	end

	always_comb begin
		dec = '0;
		for (int i = 0; i < SLOTS; i++) begin
			state_nxt[i]   = state_q[i];
			action_nxt[i]  = action_q[i];
			timeout_nxt[i] = timeout_q[i];
			cnt_nxt[i]     = cnt_q[i];
		end
		fired    = '0;
		notify   = '0;
		ex_req   = 1'b0;
		halt_req = 1'b0;
		ok       = 1'b0;
		rep_idx  = sel_idx;
		rep_ok   = sel_ok;
		slot_out = cmd.slot_sel;
		case (cmd.op)
			wdp_pkg::OP_TICK: begin
				ok = 1'b1;
				for (int i = 0; i < SLOTS; i++) begin
					if (state_q[i] == wdp_pkg::ST_RUNNING) begin
						dec        = cnt_q[i] - TIME_BITS'(1);
						cnt_nxt[i] = dec;
						if (dec == '0) begin
							state_nxt[i] = wdp_pkg::ST_TRIGGERED;
							fired[i]     = 1'b1;
							if (action_q[i] == wdp_pkg::ACT_NOTIFY) begin
								notify[i] = 1'b1;
							end
							if (action_q[i] == wdp_pkg::ACT_EXIT) begin
								ex_req = 1'b1;
							end
							if (action_q[i] == wdp_pkg::ACT_HALT) begin
								halt_req = 1'b1;
							end
						end
					end
				end
			end
			wdp_pkg::OP_START: begin
				if (free_found && cmd.timeout_len != 32'd0) begin
					ok                    = 1'b1;
					rep_idx               = free_idx;
					rep_ok                = 1'b1;
					slot_out              = 3'(free_idx);
					state_nxt[free_idx]   = wdp_pkg::ST_RUNNING;
					action_nxt[free_idx]  = cmd.action_code;
					timeout_nxt[free_idx] = tlen_sat;
					cnt_nxt[free_idx]     = tlen_sat;
				end else begin
					rep_ok   = 1'b0;
					slot_out = 3'd0;
				end
			end
			wdp_pkg::OP_CANCEL: begin
				if (sel_ok && state_q[sel_idx] == wdp_pkg::ST_RUNNING) begin
					ok                 = 1'b1;
					state_nxt[sel_idx] = wdp_pkg::ST_CANCELLED;
				end
			end
			wdp_pkg::OP_KICK: begin
				if (sel_ok && state_q[sel_idx] == wdp_pkg::ST_RUNNING) begin
					ok               = 1'b1;
					cnt_nxt[sel_idx] = timeout_q[sel_idx];
				end
			end
			wdp_pkg::OP_QUERY: begin
				ok = 1'b1;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	assign rep_state = rep_ok ? state_nxt[rep_idx] : wdp_pkg::ST_UNUSED;
	assign rep_cnt   = (rep_state == wdp_pkg::ST_RUNNING) ? cnt_nxt[rep_idx] : '0;

	assign res.ok           = ok;
	assign res.slot_out     = slot_out;
	assign res.slot_status  = rep_state;
	assign res.time_left    = rep_left;
	assign res.fired_mask   = fired[7:0];
	assign res.notify_mask  = notify[7:0];
	assign res.exit_request = ex_req;
	assign res.halt_request = halt_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				state_q[i]  <= wdp_pkg::ST_UNUSED;
				action_q[i] <= wdp_pkg::ACT_NONE;
			end
		end else if (cmd_en) begin
			for (int i = 0; i < SLOTS; i++) begin
				state_q[i]  <= state_nxt[i];
				action_q[i] <= action_nxt[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_en) begin
			for (int i = 0; i < SLOTS; i++) begin
				timeout_q[i] <= timeout_nxt[i];
				cnt_q[i]     <= cnt_nxt[i];
			end
		end
	end

endmodule

`default_nettype wire

// File: dv/tb_multi_slot_watchdog_pool_top.sv
// Self-checking testbench for the multi-slot watchdog pool top level.
// Drives commands over the input stream, predicts every result and checks the output stream.
// Depends on wdp_pkg and multi_slot_watchdog_pool_top.
`timescale 1ns / 100ps

module tb_multi_slot_watchdog_pool_top;

	localparam int NSLOT = 8;
	localparam int LIMIT_CYCLES = 200000;
	localparam int RAND_PER_PHASE = 310;
	localparam int HOLD_CYCLES = 80;
	localparam int MAX_SHOWN = 10;

	localparam logic [2:0] OP_SPARE5 = 3'd5;
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	typedef struct packed {
		logic chk;
		wdp_pkg::cmd_t cmd;
		wdp_pkg::res_t res;
	} dir_row_t;

	localparam wdp_pkg::res_t NO_RES = '0;
	localparam wdp_pkg::res_t REJECT_RES = '0;
	localparam int DIR_ROWS = 25;

	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		'{1'b1, '{wdp_pkg::OP_QUERY, 3'd7, 32'd0, wdp_pkg::ACT_NONE},
			'{1'b1, 3'd7, wdp_pkg::ST_UNUSED, 32'd0, 8'd0, 8'd0, 1'b0, 1'b0}},
		'{1'b1, '{wdp_pkg::OP_START, 3'd5, 32'd0, wdp_pkg::ACT_HALT}, REJECT_RES},
		'{1'b1, '{wdp_pkg::OP_START, 3'd0, 32'hFFFF_FFFF, wdp_pkg::ACT_NONE},
			'{1'b1, 3'd0, wdp_pkg::ST_RUNNING, 32'hFFFF_FFFF, 8'd0, 8'd0, 1'b0, 1'b0}},
		'{1'b1, '{wdp_pkg::OP_START, 3'd0, 32'd1, wdp_pkg::ACT_NOTIFY},
			'{1'b1, 3'd1, wdp_pkg::ST_RUNNING, 32'd1, 8'd0, 8'd0, 1'b0, 1'b0}},
		'{1'b0, '{wdp_pkg::OP_START, 3'd6, 32'd2, wdp_pkg::ACT_EXIT}, NO_RES},
		'{1'b0, '{wdp_pkg::OP_START, 3'd0, 32'd1, wdp_pkg::ACT_HALT}, NO_RES},
		'{1'b0, '{wdp_pkg::OP_TICK, 3'd1, 32'd0, wdp_pkg::ACT_NONE}, NO_RES},
		'{1'b0, '{wdp_pkg::OP_TICK, 3'd2, 32'd7, wdp_pkg::ACT_HALT}, NO_RES},
		'{1'b0, '{wdp_pkg::OP_KICK, 3'd0, 32'd0, wdp_pkg::ACT_NONE}, NO_RES},
		'{1'b0, '{wdp_pkg::OP_KICK, 3'd1, 32'd0, wdp_pkg::ACT_NONE}, NO_RES},
		'{1'b0, '{wdp_pkg::OP_CANCEL, 3'd0, 32'd0, wdp_pkg::ACT_NONE}, NO_RES},
		'{1'b0, '{wdp_pkg::OP_CANCEL, 3'd0, 32'd0, wdp_pkg::ACT_NONE}, NO_RES},
		'{1'b0, '{OP_SPARE5, 3'd4, 32'd9, wdp_pkg::ACT_EXIT}, NO_RES},
		'{1'b0, '{OP_SPARE6, 3'd3, 32'd0, wdp_pkg::ACT_NONE}, NO_RES},
		'{1'b0, '{OP_SPARE7, 3'd7, 32'hFFFF_FFFF, wdp_pkg::ACT_HALT}, NO_RES},
		'{1'b0, '{wdp_pkg::OP_START, 3'd0, 32'd3, wdp_pkg::ACT_NOTIFY}, NO_RES},
		'{1'b0, '{wdp_pkg::OP_START, 3'd0, 32'h8000_0000, wdp_pkg::ACT_HALT}, NO_RES},
		'{1'b0, '{wdp_pkg::OP_START, 3'd0, 32'd5, wdp_pkg::ACT_EXIT}, NO_RES},
		'{1'b0, '{wdp_pkg::OP_START, 3'd0, 32'd4, wdp_pkg::ACT_NONE}, NO_RES},
		'{1'b0, '{wdp_pkg::OP_START, 3'd0, 32'h7FFF_FFFF, wdp_pkg::ACT_NOTIFY}, NO_RES},
		'{1'b0, '{wdp_pkg::OP_START, 3'd0, 32'd2, wdp_pkg::ACT_HALT}, NO_RES},
		'{1'b0, '{wdp_pkg::OP_START, 3'd0, 32'd6, wdp_pkg::ACT_EXIT}, NO_RES},
		'{1'b0, '{wdp_pkg::OP_START, 3'd0, 32'd1, wdp_pkg::ACT_NOTIFY}, NO_RES},
		'{1'b1, '{wdp_pkg::OP_START, 3'd0, 32'd9, wdp_pkg::ACT_NOTIFY}, REJECT_RES},
		'{1'b0, '{wdp_pkg::OP_TICK, 3'd0, 32'd0, wdp_pkg::ACT_NONE}, NO_RES}
	};

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [55:0] m_tdata;

	wdp_pkg::slot_st_t wd_state [NSLOT];
	wdp_pkg::act_t wd_action [NSLOT];
	logic [31:0] wd_timeout [NSLOT];
	logic [31:0] wd_count [NSLOT];

	wdp_pkg::res_t due_results [$];
	int err_cnt = 0;
	int cycle_cnt = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	logic hold_go = 1'b0;
	logic hold_active = 1'b0;
	wdp_pkg::res_t rx_got;
	wdp_pkg::res_t rx_want;

	multi_slot_watchdog_pool_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < NSLOT; i++) begin
			wd_state[i] = wdp_pkg::ST_UNUSED;
			wd_action[i] = wdp_pkg::ACT_NONE;
			wd_timeout[i] = '0;
			wd_count[i] = '0;
		end
	end

	function automatic wdp_pkg::res_t wdog_apply(wdp_pkg::cmd_t c);
		wdp_pkg::res_t r;
		logic ok_b;
		logic [2:0] rep;
		logic found;
		logic [7:0] fired;
		logic [7:0] notif;
		logic ex;
		logic hl;
		r = '0;
		ok_b = 1'b0;
		rep = c.slot_sel;
		found = 1'b0;
		fired = '0;
		notif = '0;
		ex = 1'b0;
		hl = 1'b0;
		case (c.op)
			wdp_pkg::OP_TICK: begin
				ok_b = 1'b1;
				for (int i = 0; i < NSLOT; i++) begin
					if (wd_state[i] == wdp_pkg::ST_RUNNING) begin
						wd_count[i] = wd_count[i] - 32'd1;
						if (wd_count[i] == '0) begin
							wd_state[i] = wdp_pkg::ST_TRIGGERED;
							fired[i] = 1'b1;
							if (wd_action[i] == wdp_pkg::ACT_NOTIFY) notif[i] = 1'b1;
							if (wd_action[i] == wdp_pkg::ACT_EXIT) ex = 1'b1;
							if (wd_action[i] == wdp_pkg::ACT_HALT) hl = 1'b1;
						end
					end
				end
			end
			wdp_pkg::OP_START: begin
				if (c.timeout_len != '0) begin
					for (int i = 0; i < NSLOT; i++) begin
						if (!found && wd_state[i] != wdp_pkg::ST_RUNNING) begin
							found = 1'b1;
							rep = i[2:0];
						end
					end
				end
				if (!found)
					return REJECT_RES;
				ok_b = 1'b1;
				wd_state[rep] = wdp_pkg::ST_RUNNING;
				wd_action[rep] = wdp_pkg::act_t'(c.action_code);
				wd_timeout[rep] = c.timeout_len;
				wd_count[rep] = c.timeout_len;
			end
			wdp_pkg::OP_CANCEL, wdp_pkg::OP_KICK: begin
				if (wd_state[rep] == wdp_pkg::ST_RUNNING) begin
					ok_b = 1'b1;
					if (c.op == wdp_pkg::OP_CANCEL)
						wd_state[rep] = wdp_pkg::ST_CANCELLED;
					else
						wd_count[rep] = wd_timeout[rep];
				end
			end
			wdp_pkg::OP_QUERY: ok_b = 1'b1;
			default: ok_b = 1'b0;
		endcase
		r.ok = ok_b;
		r.slot_out = rep;
		r.slot_status = wd_state[rep];
		r.time_left = (wd_state[rep] == wdp_pkg::ST_RUNNING) ? wd_count[rep] : '0;
		r.fired_mask = fired;
		r.notify_mask = notif;
		r.exit_request = ex;
		r.halt_request = hl;
		return r;
	endfunction

	function automatic wdp_pkg::res_t unpack_result(logic [55:0] d);
		wdp_pkg::res_t r;
		r.ok = d[0];
		r.slot_out = d[3:1];
		r.slot_status = d[5:4];
		r.time_left = d[37:6];
		r.fired_mask = d[45:38];
		r.notify_mask = d[53:46];
		r.exit_request = d[54];
		r.halt_request = d[55];
		return r;
	endfunction

	task automatic show_result(string tag, wdp_pkg::res_t r);
		$display("  %s ok=%0d slot=%0d st=%0d left=%0h fired=%02h notif=%02h ex=%0d halt=%0d",
			tag, r.ok, r.slot_out, r.slot_status, r.time_left, r.fired_mask,
			r.notify_mask, r.exit_request, r.halt_request);
	endtask

	// The ready for the next cycle is chosen after the current transfer has been checked.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (m_tvalid && m_tready) begin
			rx_got = unpack_result(m_tdata);
			if (due_results.size() == 0) begin
				if (err_cnt < MAX_SHOWN) begin
					$display("Result transfer with nothing outstanding at %0t", $realtime);
					show_result("actual:  ", rx_got);
				end
				err_cnt++;
			end else begin
				rx_want = due_results.pop_front();
				if (rx_got.ok !== rx_want.ok || rx_got.slot_out !== rx_want.slot_out
						|| rx_got.slot_status !== rx_want.slot_status
						|| rx_got.time_left !== rx_want.time_left
						|| rx_got.fired_mask !== rx_want.fired_mask
						|| rx_got.notify_mask !== rx_want.notify_mask
						|| rx_got.exit_request !== rx_want.exit_request
						|| rx_got.halt_request !== rx_want.halt_request) begin
					if (err_cnt < MAX_SHOWN) begin
						$display("Result mismatch at %0t", $realtime);
						show_result("expected:", rx_want);
						show_result("actual:  ", rx_got);
					end
					err_cnt++;
				end
			end
		end
		m_tready <= !hold_active && ($urandom_range(99) >= rx_stall_pct);
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		wait (hold_go);
		hold_active <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active <= 1'b0;
	end

	task automatic issue_cmd(wdp_pkg::cmd_t c, logic fixed, wdp_pkg::res_t fixed_res);
		wdp_pkg::res_t want;
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= c.op;
		s_tdata <= {3'b000, c.action_code, c.timeout_len, c.slot_sel};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		want = wdog_apply(c);
		if (fixed)
			want = fixed_res;
		due_results.push_back(want);
	endtask

	function automatic wdp_pkg::cmd_t random_cmd();
		wdp_pkg::cmd_t c;
		int pick;
		pick = $urandom_range(99);
		if (pick < 40)
			c.op = wdp_pkg::OP_TICK;
		else if (pick < 62)
			c.op = wdp_pkg::OP_START;
		else if (pick < 70)
			c.op = wdp_pkg::OP_CANCEL;
		else if (pick < 82)
			c.op = wdp_pkg::OP_KICK;
		else if (pick < 95)
			c.op = wdp_pkg::OP_QUERY;
		else
			c.op = 3'($urandom_range(5, 7));
		c.slot_sel = 3'($urandom_range(7));
		pick = $urandom_range(99);
		if (pick < 4)
			c.timeout_len = '0;
		else if (pick < 12)
			c.timeout_len = $urandom;
		else
			c.timeout_len = 32'($urandom_range(1, 12));
		c.action_code = 2'($urandom_range(3));
		return c;
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIR_ROWS; i++)
			issue_cmd(DIR_TAB[i].cmd, DIR_TAB[i].chk, DIR_TAB[i].res);
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
				1: begin tx_idle_pct = 70; rx_stall_pct <= 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct <= 70; end
				default: begin tx_idle_pct = 34; rx_stall_pct <= 34; end
			endcase
			if (ph == 0)
				hold_go = 1'b1;
			for (int n = 0; n < RAND_PER_PHASE; n++)
				issue_cmd(random_cmd(), 1'b0, NO_RES);
			s_tvalid <= 1'b0;
			while (due_results.size() != 0) @(posedge clk);
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
